/* hdl/isd_pkg.sv */
package isd_pkg;

    // fixed numbers of the detection rule
    localparam int unsigned GRAVITY_MG        = 1000;
    localparam int unsigned DEFAULT_WINDOW_MS = 200;
    localparam int unsigned GYRO_SCALE_SHIFT  = 4;    // gyro lsb is 1/16 dps

    // field widths
    localparam int unsigned AXIS_W      = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned ACC_TH_W    = 12;
    localparam int unsigned GYRO_TH_W   = 11;
    localparam int unsigned WINDOW_W    = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 3;

    // squared bounds and sums
    localparam int unsigned SQ_W        = 31;     // one axis squared, at most 2^30
    localparam int unsigned SUM_W       = 32;     // three axes squared
    localparam int unsigned ACC_SUM_W   = ACC_TH_W + 1;   // 1000 + threshold
    localparam int unsigned ACC_HI_SQ_W = 25;
    localparam int unsigned ACC_LO_W    = 10;
    localparam int unsigned ACC_LO_SQ_W = 20;
    localparam int unsigned GYRO_SQ_W   = 2 * GYRO_TH_W;

    // register reset values
    localparam int unsigned ACC_TH_RST  = 50;
    localparam int unsigned GYRO_TH_RST = 5;
    localparam int unsigned ACC_HI_SQ_RST = (GRAVITY_MG + ACC_TH_RST) * (GRAVITY_MG + ACC_TH_RST);
    localparam int unsigned ACC_LO_SQ_RST = (GRAVITY_MG - ACC_TH_RST) * (GRAVITY_MG - ACC_TH_RST);
    localparam int unsigned GYRO_SQ_RST   = GYRO_TH_RST * GYRO_TH_RST;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_INSTANT_ONLY = 3'd1,
        CFG_ACCEL_TH     = 3'd2,
        CFG_GYRO_TH      = 3'd3,
        CFG_WINDOW       = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RES_DISABLED  = 2'd0,
        RES_NOT_MET   = 2'd1,
        RES_SATISFIED = 2'd2
    } t_result_code;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic [TIME_W-1:0]        time_ms;
        logic                     restart;
    } t_imu_sample;

    typedef struct packed {
        t_result_code result_code;
        logic         is_still;
    } t_still_result;

endpackage

/* hdl/isd_stream_if.sv */
interface isd_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

/* hdl/imu_stillness_detector_core.sv */
// a request passes through the input register and then the result register before its result is valid
// one sample per cycle while the result side takes results; the squares, sums and bound compares sit in one stage
// a stalled result register holds the pipe; an empty input stage still fills while the result waits
// reset (synchronous, active low) empties both stages, stops the still timer and loads
// the register defaults: disabled, timed mode, 50 mg, 5 dps, 200 ms window
module imu_stillness_detector_core
    import isd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    isd_stream_if.sink            i_sample,
    isd_stream_if.source          o_result
);

    // configuration, with the threshold bounds kept squared
    logic                   r_enable;
    logic                   r_instant;
    logic [WINDOW_W-1:0]    r_window;
    logic [ACC_HI_SQ_W-1:0] r_acc_hi_sq;
    logic [ACC_LO_SQ_W-1:0] r_acc_lo_sq;
    logic                   r_acc_wide;
    logic [GYRO_SQ_W-1:0]   r_gyro_sq;

    logic [ACC_TH_W-1:0]    w_acc_th;
    logic [ACC_SUM_W-1:0]   w_acc_hi;
    logic [ACC_LO_W-1:0]    w_acc_lo;
    logic [GYRO_TH_W-1:0]   w_gyro_th;
    logic [2*ACC_SUM_W-1:0] w_acc_hi_prod;
    logic [2*ACC_LO_W-1:0]  w_acc_lo_prod;
    logic [GYRO_SQ_W-1:0]   w_gyro_prod;

    assign w_acc_th      = i_cfg_data[ACC_TH_W-1:0];
    assign w_gyro_th     = i_cfg_data[GYRO_TH_W-1:0];
    assign w_acc_hi      = ACC_SUM_W'(GRAVITY_MG) + ACC_SUM_W'(w_acc_th);
    // only meaningful when the threshold does not exceed 1 g
    assign w_acc_lo      = ACC_LO_W'(GRAVITY_MG) - w_acc_th[ACC_LO_W-1:0];
    assign w_acc_hi_prod = w_acc_hi * w_acc_hi;
    assign w_acc_lo_prod = w_acc_lo * w_acc_lo;
    assign w_gyro_prod   = w_gyro_th * w_gyro_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_instant   <= 1'b0;
            r_window    <= '0;
            r_acc_hi_sq <= ACC_HI_SQ_W'(ACC_HI_SQ_RST);
            r_acc_lo_sq <= ACC_LO_SQ_W'(ACC_LO_SQ_RST);
            r_acc_wide  <= 1'b0;
            r_gyro_sq   <= GYRO_SQ_W'(GYRO_SQ_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:       r_enable  <= i_cfg_data[0];
                CFG_INSTANT_ONLY: r_instant <= i_cfg_data[0];
                CFG_ACCEL_TH: begin
                    r_acc_hi_sq <= w_acc_hi_prod[ACC_HI_SQ_W-1:0];
                    r_acc_lo_sq <= w_acc_lo_prod;
                    r_acc_wide  <= (w_acc_th > ACC_TH_W'(GRAVITY_MG));
                end
                CFG_GYRO_TH:      r_gyro_sq <= w_gyro_prod;
                CFG_WINDOW:       r_window  <= i_cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic        r_a_valid;
    t_imu_sample r_a;
    logic        r_o_valid;
    t_still_result r_o;
    logic        w_en_o;
    logic        w_en_a;
    logic        w_adv;

    assign w_en_o          = !r_o_valid || o_result.ready;
    assign w_en_a          = !r_a_valid || w_en_o;
    assign w_adv           = r_a_valid && w_en_o;
    assign i_sample.ready  = w_en_a;
    assign o_result.valid  = r_o_valid;
    assign o_result.payload = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a && i_sample.valid) begin
            r_a <= i_sample.payload;
        end
    end

    // instantaneous stillness
    logic signed [2*AXIS_W-1:0] w_prod [6];
    logic [SUM_W-1:0]           w_acc_sum;
    logic [SUM_W-1:0]           w_gyro_sum;
    logic                       w_acc_ok;
    logic                       w_gyro_ok;
    logic                       w_still;

    assign w_prod[0] = r_a.accel_x * r_a.accel_x;
    assign w_prod[1] = r_a.accel_y * r_a.accel_y;
    assign w_prod[2] = r_a.accel_z * r_a.accel_z;
    assign w_prod[3] = r_a.gyro_x * r_a.gyro_x;
    assign w_prod[4] = r_a.gyro_y * r_a.gyro_y;
    assign w_prod[5] = r_a.gyro_z * r_a.gyro_z;

    assign w_acc_sum  = SUM_W'(w_prod[0][SQ_W-1:0]) + SUM_W'(w_prod[1][SQ_W-1:0])
                      + SUM_W'(w_prod[2][SQ_W-1:0]);
    assign w_gyro_sum = SUM_W'(w_prod[3][SQ_W-1:0]) + SUM_W'(w_prod[4][SQ_W-1:0])
                      + SUM_W'(w_prod[5][SQ_W-1:0]);

    assign w_acc_ok  = (w_acc_sum < SUM_W'(r_acc_hi_sq))
                    && (r_acc_wide || (w_acc_sum > SUM_W'(r_acc_lo_sq)));
    // bound is (16 * th)^2 = th^2 * 256
    assign w_gyro_ok = (w_gyro_sum < SUM_W'({r_gyro_sq, {(2*GYRO_SCALE_SHIFT){1'b0}}}));
    assign w_still   = w_acc_ok && w_gyro_ok;

    // still timer
    logic              r_running;
    logic [TIME_W-1:0] r_start;
    logic              n_running;
    logic [TIME_W-1:0] n_start;
    logic              w_run0;
    logic [TIME_W-1:0] w_start0;
    logic [WINDOW_W-1:0] w_win;
    logic [TIME_W-1:0] w_elapsed;
    t_result_code      w_code;

    assign w_run0    = r_running && !r_a.restart;
    assign w_start0  = r_a.restart ? '0 : r_start;
    assign w_win     = (r_window != '0) ? r_window : WINDOW_W'(DEFAULT_WINDOW_MS);
    assign w_elapsed = r_a.time_ms - n_start;

    always_comb begin
        n_running = w_run0;
        n_start   = w_start0;
        w_code    = RES_NOT_MET;
        priority if (!r_enable) begin
            w_code = RES_DISABLED;
        end else if (r_instant) begin
            w_code = w_still ? RES_SATISFIED : RES_NOT_MET;
        end else if (w_still) begin
            n_running = 1'b1;
            // a new still run starts at this sample
            n_start   = w_run0 ? w_start0 : r_a.time_ms;
            w_code    = (w_elapsed >= TIME_W'(w_win)) ? RES_SATISFIED : RES_NOT_MET;
        end else begin
            n_running = 1'b0;
            n_start   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_start   <= '0;
        end else if (w_adv) begin
            r_running <= n_running;
            r_start   <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en_o) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o.result_code <= w_code;
            r_o.is_still    <= w_still;
        end
    end

    // checks
    a_disabled_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ((r_o.result_code == RES_DISABLED) == !r_enable))
        else $error("result code disagrees with enable");

    a_satisfied_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o.result_code == RES_SATISFIED) |-> r_o.is_still)
        else $error("satisfied result on a moving sample");

    a_timer_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_start == '0))
        else $error("stopped timer keeps a start time");

    a_no_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid |-> i_sample.ready)
        else $error("input stalled with empty result stage");

    a_restart_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_a.restart && (!r_enable || r_instant || !w_still)) |=> !r_running)
        else $error("restart left the timer running");

endmodule

/* test/stillness_predict_check.sv */
module stillness_predict_check
    import isd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_smp_valid,
    input  logic                  i_smp_ready,
    input  t_imu_sample           i_smp,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  t_still_result         i_res,
    output int                    o_mismatches,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                 enable_q;
    logic                 instant_q;
    logic [ACC_TH_W-1:0]  accel_th_q;
    logic [GYRO_TH_W-1:0] gyro_th_q;
    logic [WINDOW_W-1:0]  window_q;
    logic                 timer_on;
    logic [TIME_W-1:0]    timer_start;
    t_still_result        pending_verdicts[$];

    function automatic longint unsigned sq_sum(logic signed [AXIS_W-1:0] a,
                                               logic signed [AXIS_W-1:0] b,
                                               logic signed [AXIS_W-1:0] c);
        longint sa;
        longint sb;
        longint sc;
        sa = a;
        sb = b;
        sc = c;
        return sa * sa + sb * sb + sc * sc;
    endfunction

    function automatic bit sample_is_still(t_imu_sample s);
        longint unsigned accel_sq;
        longint unsigned gyro_sq;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned gyro_lim;
        bit              accel_ok;
        accel_sq = sq_sum(s.accel_x, s.accel_y, s.accel_z);
        gyro_sq  = sq_sum(s.gyro_x, s.gyro_y, s.gyro_z);
        hi       = GRAVITY_MG + accel_th_q;
        accel_ok = accel_sq < hi * hi;
        // lower bound only exists while the threshold stays at or below gravity
        if (accel_th_q <= GRAVITY_MG) begin
            lo       = GRAVITY_MG - accel_th_q;
            accel_ok = accel_ok && (accel_sq > lo * lo);
        end
        gyro_lim = longint'(gyro_th_q) << GYRO_SCALE_SHIFT;
        return accel_ok && (gyro_sq < gyro_lim * gyro_lim);
    endfunction

    function automatic t_still_result detect_stillness(t_imu_sample s);
        t_still_result     r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] needed;
        r.is_still = sample_is_still(s);
        if (s.restart) begin
            timer_on    = 1'b0;
            timer_start = '0;
        end
        if (!enable_q) begin
            r.result_code = RES_DISABLED;
        end else if (instant_q) begin
            r.result_code = r.is_still ? RES_SATISFIED : RES_NOT_MET;
        end else if (r.is_still) begin
            needed = (window_q == '0) ? TIME_W'(DEFAULT_WINDOW_MS) : TIME_W'(window_q);
            if (!timer_on) begin
                timer_on    = 1'b1;
                timer_start = s.time_ms;
            end
            elapsed       = s.time_ms - timer_start;
            r.result_code = (elapsed >= needed) ? RES_SATISFIED : RES_NOT_MET;
        end else begin
            timer_on      = 1'b0;
            timer_start   = '0;
            r.result_code = RES_NOT_MET;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_still_result want;
        if (!i_rst_n) begin
            enable_q    = 1'b0;
            instant_q   = 1'b0;
            accel_th_q  = ACC_TH_W'(ACC_TH_RST);
            gyro_th_q   = GYRO_TH_W'(GYRO_TH_RST);
            window_q    = '0;
            timer_on    = 1'b0;
            timer_start = '0;
            pending_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENABLE:       enable_q   = i_cfg_data[0];
                    CFG_INSTANT_ONLY: instant_q  = i_cfg_data[0];
                    CFG_ACCEL_TH:     accel_th_q = i_cfg_data[ACC_TH_W-1:0];
                    CFG_GYRO_TH:      gyro_th_q  = i_cfg_data[GYRO_TH_W-1:0];
                    CFG_WINDOW:       window_q   = i_cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp_valid && i_smp_ready) begin
                pending_verdicts.insert(pending_verdicts.size(), detect_stillness(i_smp));
            end
            if (i_res_valid && i_res_ready) begin
                if (pending_verdicts.size() == 0) begin
                    o_mismatches++;
                    $display("%0t ns: unexpected result, code %0d is_still %0b",
                             $time, i_res.result_code, i_res.is_still);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_res.result_code !== want.result_code) begin
                        o_mismatches++;
                        $display("%0t ns: result_code expected %0d actual %0d",
                                 $time, want.result_code, i_res.result_code);
                    end
                    if (i_res.is_still !== want.is_still) begin
                        o_mismatches++;
                        $display("%0t ns: is_still expected %0b actual %0b",
                                 $time, want.is_still, i_res.is_still);
                    end
                end
            end
        end
        o_outstanding = pending_verdicts.size();
    end

endmodule

/* test/tb_imu_stillness_detector_core.sv */
module tb_imu_stillness_detector_core;
    timeunit 1ns;
    timeprecision 1ps;
    import isd_pkg::*;

    localparam int HOLD_CYCLES        = 200;
    localparam int STALL_LIMIT        = 2000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int RANDOM_PHASE_ITEMS = 80;
    localparam int SIDE_TX            = 0;
    localparam int SIDE_RX            = 1;

    typedef enum int {
        RUN_STILL,
        RUN_MOTION,
        RUN_NOISE
    } t_run_kind;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    idle_run[2];
    bit                    idle_busy[2];
    bit                    rx_hold_req;

    isd_stream_if #(.T_PAYLOAD(t_imu_sample))   sample_if ();
    isd_stream_if #(.T_PAYLOAD(t_still_result)) result_if ();

    always #6 clk = ~clk;

    imu_stillness_detector_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_if),
        .o_result   (result_if)
    );

    stillness_predict_check verdict_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_smp_valid   (sample_if.valid),
        .i_smp_ready   (sample_if.ready),
        .i_smp         (sample_if.payload),
        .i_res_valid   (result_if.valid),
        .i_res_ready   (result_if.ready),
        .i_res         (result_if.payload),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // busy and quiet stretches alternate so gaps land on every phase of the pipe
    function automatic int draw_wait(int side);
        if (idle_run[side] == 0) begin
            idle_run[side]  = $urandom_range(8, 40);
            idle_busy[side] = ($urandom_range(0, 2) != 0);
        end
        idle_run[side]--;
        return idle_busy[side] ? $urandom_range(0, 13) : 0;
    endfunction

    function automatic int signed_pick(int mag);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    function automatic t_imu_sample mk_sample(int ax, int ay, int az, int gx, int gy, int gz,
                                              logic [TIME_W-1:0] t, logic restart);
        t_imu_sample s;
        s.accel_x = AXIS_W'(ax);
        s.accel_y = AXIS_W'(ay);
        s.accel_z = AXIS_W'(az);
        s.gyro_x  = AXIS_W'(gx);
        s.gyro_y  = AXIS_W'(gy);
        s.gyro_z  = AXIS_W'(gz);
        s.time_ms = t;
        s.restart = restart;
        return s;
    endfunction

    function automatic t_imu_sample random_sample(t_run_kind kind, int acc_th, int gyr_th,
                                                  logic [TIME_W-1:0] t, logic restart);
        int          acc[3];
        int          gyr[3];
        int          lim;
        int          dom;
        int          dev;
        bit          bad_accel;
        t_imu_sample s;
        lim = gyr_th * 16;
        for (int i = 0; i < 3; i++) begin
            acc[i] = signed_pick($urandom_range(0, 20));
            gyr[i] = signed_pick($urandom_range(0, lim / 2));
        end
        dom = $urandom_range(0, 2);
        case (kind)
            RUN_STILL: dev = signed_pick($urandom_range(0, acc_th));
            RUN_MOTION: begin
                bad_accel = $urandom_range(0, 1);
                if (bad_accel) begin
                    dev = signed_pick(acc_th + $urandom_range(0, 600));
                end else begin
                    dev      = signed_pick($urandom_range(0, acc_th));
                    gyr[dom] = signed_pick($urandom_range(lim / 2, lim + 2000));
                end
            end
            default: dev = 0;
        endcase
        acc[dom] = signed_pick(int'(GRAVITY_MG) + dev);
        s = mk_sample(acc[0], acc[1], acc[2], gyr[0], gyr[1], gyr[2], t, restart);
        if (kind == RUN_NOISE) begin
            s.accel_x = AXIS_W'($urandom);
            s.accel_y = AXIS_W'($urandom);
            s.accel_z = AXIS_W'($urandom);
            s.gyro_x  = AXIS_W'($urandom);
            s.gyro_y  = AXIS_W'($urandom);
            s.gyro_z  = AXIS_W'($urandom);
        end
        return s;
    endfunction

    task automatic send_sample(t_imu_sample s);
        int gap;
        gap = draw_wait(SIDE_TX);
        @(negedge clk);
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.payload <= s;
        do begin
            @(posedge clk);
        end while (!sample_if.ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setup(logic en, logic inst, int acc, int gyr, int win);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ENABLE;
        cfg_data <= CFG_DATA_W'(en);
        @(negedge clk);
        cfg_idx  <= CFG_INSTANT_ONLY;
        cfg_data <= CFG_DATA_W'(inst);
        @(negedge clk);
        cfg_idx  <= CFG_ACCEL_TH;
        cfg_data <= CFG_DATA_W'(acc);
        @(negedge clk);
        cfg_idx  <= CFG_GYRO_TH;
        cfg_data <= CFG_DATA_W'(gyr);
        @(negedge clk);
        cfg_idx  <= CFG_WINDOW;
        cfg_data <= CFG_DATA_W'(win);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_random_phase(logic en, logic inst, int acc, int gyr, int win,
                                    bit squeeze);
        int                run_left;
        int                span;
        int                r;
        t_run_kind         kind;
        logic [TIME_W-1:0] t;
        wait_idle();
        apply_setup(en, inst, acc, gyr, win);
        span = (win == 0) ? DEFAULT_WINDOW_MS : win;
        // some phases start just short of the timestamp wrap
        if ($urandom_range(0, 3) == 0) begin
            t = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
        end else begin
            t = $urandom;
        end
        run_left    = 0;
        kind        = RUN_STILL;
        rx_hold_req = squeeze;
        repeat (RANDOM_PHASE_ITEMS) begin
            if (run_left == 0) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    kind     = RUN_STILL;
                    run_left = $urandom_range(3, 30);
                end else if (r < 9) begin
                    kind     = RUN_MOTION;
                    run_left = $urandom_range(1, 4);
                end else begin
                    kind     = RUN_NOISE;
                    run_left = $urandom_range(1, 3);
                end
            end
            run_left--;
            t += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, span / 5 + 1);
            send_sample(random_sample(kind, acc, gyr, t, $urandom_range(0, 29) == 0));
        end
    endtask

    // result side: random stalls, one long hold-off when asked
    initial begin
        int stall;
        result_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                stall = draw_wait(SIDE_RX);
                if (stall > 0) begin
                    result_if.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            result_if.ready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!result_if.valid);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("imu_stillness_detector_core verification failed");
        $finish;
    end

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_ENABLE;
        cfg_data          <= '0;
        sample_if.valid   <= 1'b0;
        sample_if.payload <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // disabled after reset: is_still reported, restart accepted
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 100, 1'b0));
        send_sample(mk_sample(-32768, -32768, -32768, -32768, -32768, -32768,
                              32'hFFFF_FFFF, 1'b1));
        send_sample(mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 0, 1'b0));

        wait_idle();
        apply_setup(1'b1, 1'b0, 50, 5, 0);
        // default 200 ms window, restart and motion both stop the timer
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 1000, 1'b0));
        send_sample(mk_sample(0, 1000, 0, 0, 0, 0, 1199, 1'b0));
        send_sample(mk_sample(0, 0, -1000, 0, 0, 0, 1200, 1'b0));
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 1300, 1'b1));
        send_sample(mk_sample(1100, 0, 0, 0, 0, 0, 1500, 1'b0));
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 1600, 1'b0));
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 1800, 1'b0));
        // accel magnitude right at and inside both bounds
        send_sample(mk_sample(1050, 0, 0, 0, 0, 0, 1900, 1'b0));
        send_sample(mk_sample(0, -1049, 0, 0, 0, 0, 1910, 1'b0));
        send_sample(mk_sample(0, 0, 950, 0, 0, 0, 1920, 1'b0));
        send_sample(mk_sample(951, 0, 0, 0, 0, 0, 1930, 1'b0));
        // gyro just under and at the bound
        send_sample(mk_sample(1000, 0, 0, 79, 0, 0, 1940, 1'b0));
        send_sample(mk_sample(1000, 0, 0, 0, 0, -80, 1950, 1'b0));
        // still run across the timestamp wrap, then time stepping back
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 32'hFFFF_FF00, 1'b0));
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 32'h0000_0010, 1'b0));
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 32'h0000_0005, 1'b0));

        // zero thresholds never pass
        wait_idle();
        apply_setup(1'b1, 1'b1, 0, 0, 0);
        send_sample(mk_sample(1000, 0, 0, 0, 0, 0, 100, 1'b0));

        // wide thresholds above 1 g: no lower accel bound
        wait_idle();
        apply_setup(1'b1, 1'b1, 4000, 2000, 0);
        send_sample(mk_sample(0, 0, 0, 0, 0, 0, 200, 1'b0));
        send_sample(mk_sample(-32768, -32768, -32768, 0, 0, 0, 300, 1'b0));
        send_sample(mk_sample(4999, 0, 0, 31999, 0, 0, 400, 1'b0));

        run_random_phase(1'b1, 1'b0, 50, 5, 0, 1'b0);
        run_random_phase(1'b1, 1'b0, 120, 40, 1, 1'b1);
        run_random_phase(1'b1, 1'b1, 80, 20, 0, 1'b0);
        run_random_phase(1'b1, 1'b0, 4000, 2000, 65535, 1'b0);
        run_random_phase(1'b0, 1'b0, 300, 100, 50, 1'b0);
        run_random_phase(1'b1, 1'b0, 1000, 1, 500, 1'b0);
        run_random_phase(1'b1, 1'b0, 1001, 10, 30, 1'b0);
        run_random_phase(1'b1, 1'b0, 0, 50, 100, 1'b0);
        run_random_phase(1'b1, 1'b1, 200, 0, 0, 1'b0);
        repeat (2) begin
            run_random_phase($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 4000), $urandom_range(0, 2000),
                             $urandom_range(0, 2000), 1'b0);
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("imu_stillness_detector_core verification clean");
        end else begin
            $display("imu_stillness_detector_core verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/isd_pkg.sv
hdl/isd_stream_if.sv
hdl/imu_stillness_detector_core.sv
test/stillness_predict_check.sv
test/tb_imu_stillness_detector_core.sv
